FILE: rtl/elf_header_validator_core_defines.svh
// Assertion macros for the checker file of the ELF header validator.
`ifndef ELF_HEADER_VALIDATOR_CORE_DEFINES_SVH
`define ELF_HEADER_VALIDATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EHV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EHV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ehv_pkg.sv
// Types and constants shared by the ELF header validator modules.
package ehv_pkg;

   localparam int HEADER_BYTES = 64;
   localparam int POS_W        = 7;

   localparam logic [7:0]  ELFMAG0     = 8'h7F;
   localparam logic [7:0]  ELFMAG1     = 8'h45;
   localparam logic [7:0]  ELFMAG2     = 8'h4C;
   localparam logic [7:0]  ELFMAG3     = 8'h46;
   localparam logic [7:0]  ELFCLASS32  = 8'd1;
   localparam logic [7:0]  ELFCLASS64  = 8'd2;
   localparam logic [7:0]  ELFDATA2LSB = 8'd1;
   localparam logic [7:0]  ELFDATA2MSB = 8'd2;
   localparam logic [7:0]  ELF_VERSION = 8'd1;
   localparam logic [15:0] SHSTR_EXTENDED = 16'hFFFF;
   localparam logic [15:0] IDENT_LEN   = 16'd16;

   localparam logic [15:0] EHDR32_BYTES = 16'd52;
   localparam logic [15:0] EHDR64_BYTES = 16'd64;
   localparam logic [15:0] SHENT32      = 16'd40;
   localparam logic [15:0] SHENT64      = 16'd64;
   localparam logic [15:0] PHENT32      = 16'd32;
   localparam logic [15:0] PHENT64      = 16'd56;

   localparam logic [1:0] VERDICT_INVALID = 2'd0;
   localparam logic [1:0] VERDICT_32      = 2'd1;
   localparam logic [1:0] VERDICT_64      = 2'd2;
   localparam logic [1:0] VERDICT_SHORT   = 2'd3;

   typedef struct packed {
      logic capture;
      logic decode;
      logic math;
      logic judge;
   } ehv_cmd_type;

endpackage

FILE: rtl/ehv_ctrl.sv
// Controller that sequences byte capture and the three verdict steps.
module ehv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_last,
   output logic                busy,
   output logic                rsp_strobe,
   output ehv_pkg::ehv_cmd_type cmd
);
   import ehv_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_MATH   = 2'd2;
   localparam logic [1:0] ST_JUDGE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: state_in = ST_MATH;
         ST_MATH:   state_in = ST_JUDGE;
         ST_JUDGE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign strobe_in = (state_ff == ST_JUDGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign cmd.capture = accept;
   assign cmd.decode  = (state_ff == ST_DECODE);
   assign cmd.math    = (state_ff == ST_MATH);
   assign cmd.judge   = (state_ff == ST_JUDGE);

endmodule

FILE: rtl/ehv_datapath.sv
// Header byte store, field decode, extent arithmetic and verdict register.
module ehv_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ehv_pkg::ehv_cmd_type cmd,
   input  logic [7:0]           req_header_byte,
   input  logic [63:0]          req_file_size,
   input  logic                 req_last,
   output logic [1:0]           rsp_verdict
);
   import ehv_pkg::*;

   // Byte store and position counter.
   logic [7:0]       hdr_ff [HEADER_BYTES];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0]      size_ff;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.capture) begin
         if (req_last) begin
            pos_in = '0;
         end else if (!pos_ff[POS_W-1]) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && !pos_ff[POS_W-1]) begin
         hdr_ff[pos_ff[POS_W-2:0]] <= req_header_byte;
      end
      if (cmd.capture && req_last) begin
         size_ff <= req_file_size;
      end
   end

   // Decode step: pick the class-dependent fields and settle the identification checks.
   logic        wide_c, ident_ok_c, early_done_c;
   logic [1:0]  cls_code_c, early_code_c;
   logic [15:0] hdr_len_c, ehsize_c, phent_c, phnum_c, shent_c, shnum_c, shstr_c;
   logic [63:0] phoff_c, shoff_c;

   assign wide_c     = (hdr_ff[4] == ELFCLASS64);
   assign cls_code_c = wide_c ? VERDICT_64 : VERDICT_32;
   assign hdr_len_c  = wide_c ? EHDR64_BYTES : EHDR32_BYTES;
   assign ident_ok_c = (hdr_ff[0] == ELFMAG0) && (hdr_ff[1] == ELFMAG1) &&
                       (hdr_ff[2] == ELFMAG2) && (hdr_ff[3] == ELFMAG3) &&
                       ((hdr_ff[4] == ELFCLASS32) || (hdr_ff[4] == ELFCLASS64)) &&
                       ((hdr_ff[5] == ELFDATA2LSB) || (hdr_ff[5] == ELFDATA2MSB)) &&
                       (hdr_ff[6] == ELF_VERSION);

   always_comb begin
      if (wide_c) begin
         phoff_c  = {hdr_ff[39], hdr_ff[38], hdr_ff[37], hdr_ff[36],
                     hdr_ff[35], hdr_ff[34], hdr_ff[33], hdr_ff[32]};
         shoff_c  = {hdr_ff[47], hdr_ff[46], hdr_ff[45], hdr_ff[44],
                     hdr_ff[43], hdr_ff[42], hdr_ff[41], hdr_ff[40]};
         ehsize_c = {hdr_ff[53], hdr_ff[52]};
         phent_c  = {hdr_ff[55], hdr_ff[54]};
         phnum_c  = {hdr_ff[57], hdr_ff[56]};
         shent_c  = {hdr_ff[59], hdr_ff[58]};
         shnum_c  = {hdr_ff[61], hdr_ff[60]};
         shstr_c  = {hdr_ff[63], hdr_ff[62]};
      end else begin
         phoff_c  = {32'd0, hdr_ff[31], hdr_ff[30], hdr_ff[29], hdr_ff[28]};
         shoff_c  = {32'd0, hdr_ff[35], hdr_ff[34], hdr_ff[33], hdr_ff[32]};
         ehsize_c = {hdr_ff[41], hdr_ff[40]};
         phent_c  = {hdr_ff[43], hdr_ff[42]};
         phnum_c  = {hdr_ff[45], hdr_ff[44]};
         shent_c  = {hdr_ff[47], hdr_ff[46]};
         shnum_c  = {hdr_ff[49], hdr_ff[48]};
         shstr_c  = {hdr_ff[51], hdr_ff[50]};
      end
   end

   always_comb begin
      early_done_c = 1'b1;
      early_code_c = cls_code_c;
      if (size_ff < {48'd0, IDENT_LEN}) begin
         early_code_c = VERDICT_SHORT;
      end else if (!ident_ok_c) begin
         early_code_c = VERDICT_INVALID;
      end else if (size_ff < {48'd0, hdr_len_c}) begin
         early_code_c = VERDICT_SHORT;
      end else if (hdr_ff[5] == ELFDATA2MSB) begin
         early_code_c = cls_code_c;
      end else begin
         early_done_c = 1'b0;
      end
   end

   logic        early_done_ff, ehsize_ok_ff, shent_ok_ff, phent_ok_ff, shstr_bad_ff;
   logic        shoff_nz_ff, sh_any_ff, ph_any_ff;
   logic [1:0]  early_code_ff, cls_code_ff;
   logic [15:0] phent_ff, phnum_ff, shent_ff, shnum_ff;
   logic [63:0] phoff_ff, shoff_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         early_done_ff <= early_done_c;
         early_code_ff <= early_code_c;
         cls_code_ff   <= cls_code_c;
         ehsize_ok_ff  <= (ehsize_c == hdr_len_c);
         shent_ok_ff   <= (shent_c == (wide_c ? SHENT64 : SHENT32));
         phent_ok_ff   <= (phent_c == (wide_c ? PHENT64 : PHENT32));
         // An index of SHSTR_EXTENDED means the real index lives elsewhere.
         shstr_bad_ff  <= (shstr_c >= shnum_c) && (shstr_c != SHSTR_EXTENDED);
         shoff_nz_ff   <= (shoff_c != 64'd0);
         sh_any_ff     <= (shnum_c != 16'd0);
         ph_any_ff     <= (phnum_c != 16'd0);
         phent_ff      <= phent_c;
         phnum_ff      <= phnum_c;
         shent_ff      <= shent_c;
         shnum_ff      <= shnum_c;
         phoff_ff      <= phoff_c;
         shoff_ff      <= shoff_c;
      end
   end

   // Math step: table extents and the room left after each table offset.
   logic [64:0] sh_gap_c, ph_gap_c;
   logic [31:0] sh_ext_ff, ph_ext_ff;
   logic [63:0] sh_rem_ff, ph_rem_ff;
   logic        sh_past_ff, ph_past_ff;

   assign sh_gap_c = {1'b0, size_ff} - {1'b0, shoff_ff};
   assign ph_gap_c = {1'b0, size_ff} - {1'b0, phoff_ff};

   always_ff @(posedge clock) begin
      if (cmd.math) begin
         sh_ext_ff  <= 32'(shnum_ff) * 32'(shent_ff);
         ph_ext_ff  <= 32'(phnum_ff) * 32'(phent_ff);
         sh_rem_ff  <= sh_gap_c[63:0];
         ph_rem_ff  <= ph_gap_c[63:0];
         sh_past_ff <= sh_gap_c[64];
         ph_past_ff <= ph_gap_c[64];
      end
   end

   // Judge step: apply the remaining checks in their order of precedence.
   logic       sh_fit_c, ph_fit_c, shoff_ge_c, phoff_ge_c;
   logic [1:0] verdict_c;
   logic [1:0] verdict_ff;

   assign sh_fit_c   = !sh_past_ff && ({32'd0, sh_ext_ff} <= sh_rem_ff);
   assign ph_fit_c   = !ph_past_ff && ({32'd0, ph_ext_ff} <= ph_rem_ff);
   assign shoff_ge_c = sh_past_ff || (sh_rem_ff == 64'd0);
   assign phoff_ge_c = ph_past_ff || (ph_rem_ff == 64'd0);

   always_comb begin
      if (early_done_ff) begin
         verdict_c = early_code_ff;
      end else if (!ehsize_ok_ff) begin
         verdict_c = VERDICT_INVALID;
      end else if (shoff_nz_ff && shoff_ge_c) begin
         verdict_c = VERDICT_SHORT;
      end else if (sh_any_ff && !shent_ok_ff) begin
         verdict_c = VERDICT_INVALID;
      end else if (sh_any_ff && shstr_bad_ff) begin
         verdict_c = VERDICT_INVALID;
      end else if (sh_any_ff && !sh_fit_c) begin
         verdict_c = VERDICT_SHORT;
      end else if (ph_any_ff && !phent_ok_ff) begin
         verdict_c = VERDICT_INVALID;
      end else if (ph_any_ff && (phoff_ge_c || !ph_fit_c)) begin
         verdict_c = VERDICT_SHORT;
      end else begin
         verdict_c = cls_code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.judge) begin
         verdict_ff <= verdict_c;
      end
   end

   assign rsp_verdict = verdict_ff;

endmodule

FILE: rtl/elf_header_validator_core.sv
// Top level of the ELF header validator: controller plus datapath.
//
// Usage: send the first min(file_size, 64) bytes of a file in file order, one
// request per byte, with start high. A request is taken at a clock edge where
// start is high and busy is low. req_file_size carries the file length and
// must hold for the whole file; req_last marks the final byte sent. Bytes past
// offset 63 are accepted and dropped.
// Byte requests are taken back to back, one per cycle, while busy is low.
// After the request with req_last, busy stays high while the decode, extent
// arithmetic and judge steps run in turn; rsp_strobe then pulses for one
// cycle with rsp_verdict (0 invalid, 1 valid 32-bit, 2 valid 64-bit, 3 file
// too short), both registered from the judge step. busy is already low in
// that cycle, so the next file may start there.
// The decode step, the extent step (both 16x16 multiplies and both offset
// subtractions) and the judge step run in states of their own and set the
// gap between files.
// The receiver cannot stall: each verdict must be taken in its strobe cycle.
// Synchronous reset returns the controller to idle and the byte position to
// zero; store contents are not cleared.
module elf_header_validator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_header_byte,
   input  logic [63:0] req_file_size,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict
);
   import ehv_pkg::*;

   ehv_cmd_type cmd;

   ehv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_last   (req_last),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   ehv_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_header_byte (req_header_byte),
      .req_file_size   (req_file_size),
      .req_last        (req_last),
      .rsp_verdict     (rsp_verdict)
   );

endmodule

FILE: rtl/ehv_checker.sv
// Port-level assertions for the ELF header validator and their bind.
`include "elf_header_validator_core_defines.svh"

module ehv_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_strobe
);

   logic last_taken;

   assign last_taken = start && !busy && req_last;

   `EHV_ASSERT_NEXT(a_last_sets_busy, last_taken, busy, "busy missing after last byte")
   `EHV_ASSERT_SAME(a_verdict_latency, last_taken, ##4 rsp_strobe, "verdict not on time")
   `EHV_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "verdict strobe too long")
   `EHV_ASSERT_SAME(a_strobe_idle, rsp_strobe, !busy, "verdict strobe while busy")

endmodule

bind elf_header_validator_core ehv_checker u_ehv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_last   (req_last),
   .rsp_strobe (rsp_strobe)
);

FILE: verif/tb_elf_header_validator_core.sv
// Self-checking testbench for the ELF header validator core.
`timescale 1ns / 100ps

module tb_elf_header_validator_core;
   import ehv_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_BYTES = 440;
   localparam int unsigned CALM_BYTES   = 330;

   // Keeps its own copy of the header store and judges each file at its last byte.
   class verdict_tracker;
      logic [7:0]  hdr [HEADER_BYTES];
      int unsigned fill;
      logic [1:0]  expected_verdicts [$];
      int unsigned errors;
      int unsigned tally [4];

      function new();
         foreach (hdr[i]) hdr[i] = 8'h00;
         foreach (tally[i]) tally[i] = 0;
         fill = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      function logic [63:0] le_field(int at, int n);
         logic [63:0] v;
         v = '0;
         for (int i = 0; i < n; i++) v[8*i +: 8] = hdr[6'((at + i) % HEADER_BYTES)];
         return v;
      endfunction

      function bit fits(logic [63:0] off, logic [63:0] ext, logic [63:0] size);
         return off <= size && ext <= size - off;
      endfunction

      function logic [1:0] judge_header(logic [63:0] size);
         logic [7:0]  cls, dat;
         logic [1:0]  class_verdict;
         logic [63:0] hsz, phoff, shoff, ehsize, phent, phnum, shent, shnum, shstr;
         logic [63:0] want_sh, want_ph;
         bit          wide;
         int          p;
         if (size < 64'(IDENT_LEN)) return VERDICT_SHORT;
         if (hdr[0] != ELFMAG0 || hdr[1] != ELFMAG1 || hdr[2] != ELFMAG2 ||
             hdr[3] != ELFMAG3) return VERDICT_INVALID;
         cls = hdr[4];
         dat = hdr[5];
         if (cls != ELFCLASS32 && cls != ELFCLASS64) return VERDICT_INVALID;
         if (dat != ELFDATA2LSB && dat != ELFDATA2MSB) return VERDICT_INVALID;
         if (hdr[6] != ELF_VERSION) return VERDICT_INVALID;
         wide = (cls == ELFCLASS64);
         hsz = 64'(wide ? EHDR64_BYTES : EHDR32_BYTES);
         class_verdict = wide ? VERDICT_64 : VERDICT_32;
         if (size < hsz) return VERDICT_SHORT;
         // Big-endian headers stop after the identification checks.
         if (dat == ELFDATA2MSB) return class_verdict;
         if (wide) begin
            phoff = le_field(32, 8);
            shoff = le_field(40, 8);
            p = 52;
            want_sh = 64'(SHENT64);
            want_ph = 64'(PHENT64);
         end else begin
            phoff = le_field(28, 4);
            shoff = le_field(32, 4);
            p = 40;
            want_sh = 64'(SHENT32);
            want_ph = 64'(PHENT32);
         end
         ehsize = le_field(p, 2);
         phent  = le_field(p + 2, 2);
         phnum  = le_field(p + 4, 2);
         shent  = le_field(p + 6, 2);
         shnum  = le_field(p + 8, 2);
         shstr  = le_field(p + 10, 2);
         if (ehsize != hsz) return VERDICT_INVALID;
         if (shoff != 0 && shoff >= size) return VERDICT_SHORT;
         if (shnum != 0) begin
            if (shent != want_sh) return VERDICT_INVALID;
            if (shstr >= shnum && shstr != 64'(SHSTR_EXTENDED)) return VERDICT_INVALID;
            if (!fits(shoff, shnum * shent, size)) return VERDICT_SHORT;
         end
         if (phnum != 0) begin
            if (phent != want_ph) return VERDICT_INVALID;
            if (phoff >= size) return VERDICT_SHORT;
            if (!fits(phoff, phnum * phent, size)) return VERDICT_SHORT;
         end
         return class_verdict;
      endfunction

      function void note_request(logic [7:0] b, logic [63:0] size, logic lst);
         if (fill < HEADER_BYTES) begin
            hdr[6'(fill)] = b;
            fill++;
         end
         if (lst) begin
            expected_verdicts.push_back(judge_header(size));
            fill = 0;
         end
      endfunction

      task check_verdict(logic [1:0] got);
         logic [1:0] want;
         if (expected_verdicts.size() == 0) begin
            report($sformatf("verdict %0d with no file outstanding", got));
         end else begin
            want = expected_verdicts.pop_front();
            tally[want]++;
            if (got !== want) report($sformatf("verdict %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_header_byte = 8'h00;
   logic [63:0] req_file_size = 64'd0;
   logic        req_last = 1'b0;
   logic        rsp_strobe;
   logic [1:0]  rsp_verdict;

   verdict_tracker board = new();
   logic [7:0]     img [HEADER_BYTES];
   int unsigned    bytes_sent = 0;
   int unsigned    cycle_count = 0;
   int unsigned    idle_pct = 0;
   bit             idle_on = 1'b1;

   elf_header_validator_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_header_byte (req_header_byte),
      .req_file_size   (req_file_size),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_verdict     (rsp_verdict)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe === 1'b1) board.check_verdict(rsp_verdict);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles.", cycle_count);
      $display("elf_header_validator_core test failed");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_upto(logic [63:0] limit);
      if (&limit) return rand64();
      return rand64() % (limit + 64'd1);
   endfunction

   function automatic void put_le(int at, int n, logic [63:0] val);
      for (int i = 0; i < n; i++) img[6'(at + i)] = val[8*i +: 8];
   endfunction

   function automatic void set_tables(bit wide, logic [63:0] phoff, logic [63:0] shoff,
                                      logic [15:0] ehsize, logic [15:0] phent,
                                      logic [15:0] phnum, logic [15:0] shent,
                                      logic [15:0] shnum, logic [15:0] shstr);
      int p;
      if (wide) begin
         put_le(32, 8, phoff);
         put_le(40, 8, shoff);
         p = 52;
      end else begin
         put_le(28, 4, phoff);
         put_le(32, 4, shoff);
         p = 40;
      end
      put_le(p, 2, ehsize);
      put_le(p + 2, 2, phent);
      put_le(p + 4, 2, phnum);
      put_le(p + 6, 2, shent);
      put_le(p + 8, 2, shnum);
      put_le(p + 10, 2, shstr);
   endfunction

   // A well-formed header with no tables; the unused bytes are random.
   function automatic void base_header(logic [7:0] cls, logic [7:0] dat);
      bit wide;
      wide = (cls == ELFCLASS64);
      foreach (img[i]) img[i] = 8'($urandom);
      img[0] = ELFMAG0;
      img[1] = ELFMAG1;
      img[2] = ELFMAG2;
      img[3] = ELFMAG3;
      img[4] = cls;
      img[5] = dat;
      img[6] = ELF_VERSION;
      set_tables(wide, '0, '0, wide ? EHDR64_BYTES : EHDR32_BYTES,
                 wide ? PHENT64 : PHENT32, '0, wide ? SHENT64 : SHENT32, '0, '0);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [63:0] size, input logic lst);
      if (idle_on && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_header_byte <= b;
      req_file_size <= size;
      req_last <= lst;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(b, size, lst);
      bytes_sent++;
   endtask

   // Sends at least min(size, 64) bytes so that every byte the verdict reads was written.
   task automatic send_file(input logic [63:0] size, input int unsigned extra);
      int unsigned n;
      n = (size < 64'(HEADER_BYTES)) ? 32'(size) : HEADER_BYTES;
      if (n == 0) n = 1;
      n += extra;
      for (int unsigned i = 0; i < n; i++)
         send_byte((i < HEADER_BYTES) ? img[6'(i)] : 8'($urandom), size, i == n - 1);
   endtask

   task automatic wait_for_verdicts();
      start <= 1'b0;
      do @(posedge clock); while (board.expected_verdicts.size() != 0);
   endtask

   function automatic logic [63:0] pick_offset(logic [63:0] size, logic [63:0] ext, bit wide);
      logic [63:0] off;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (size < ext) off = rand64();
      else if (r < 60) off = rand_upto(size - ext);
      else if (r < 70) off = size - ext;
      else if (r < 78) off = size - ext + 64'd1;
      else if (r < 84) off = size;
      else if (r < 90) off = '0;
      else off = rand64();
      if (!wide) off[63:32] = '0;
      return off;
   endfunction

   function automatic logic [15:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 80) return 16'($urandom_range(1, 12));
      if (r < 92) return 16'($urandom);
      return 16'hFFFF;
   endfunction

   // Mostly well-formed headers with random table layouts; a share is corrupted.
   task automatic random_file();
      logic [7:0]  cls, dat;
      logic [63:0] size, hsz, phoff, shoff;
      logic [15:0] ehsize, phent, phnum, shent, shnum, shstr;
      int unsigned r;
      bit          wide;
      r = $urandom_range(0, 99);
      cls = (r < 45) ? ELFCLASS32 : (r < 90) ? ELFCLASS64 : 8'($urandom);
      r = $urandom_range(0, 99);
      dat = (r < 75) ? ELFDATA2LSB : (r < 92) ? ELFDATA2MSB : 8'($urandom);
      wide = (cls == ELFCLASS64);
      hsz = 64'(wide ? EHDR64_BYTES : EHDR32_BYTES);
      base_header(cls, dat);

      r = $urandom_range(0, 99);
      if (r < 6) size = 64'($urandom_range(0, 15));
      else if (r < 12) size = 64'($urandom_range(16, int'(hsz) - 1));
      else if (r < 17) size = hsz;
      else if (r < 65) size = hsz + 64'($urandom_range(0, 4000));
      else if (r < 80) size = hsz + 64'($urandom_range(0, 1 << 20));
      else if (r < 92) size = rand64();
      else if (r < 97) size = '1;
      else size = {32'h0, $urandom};

      ehsize = ($urandom_range(0, 99) < 92) ? hsz[15:0] : 16'($urandom);
      phent = ($urandom_range(0, 9) != 0) ? (wide ? PHENT64 : PHENT32) : 16'($urandom);
      shent = ($urandom_range(0, 9) != 0) ? (wide ? SHENT64 : SHENT32) : 16'($urandom);
      phnum = pick_count();
      shnum = pick_count();
      r = $urandom_range(0, 99);
      if (r < 60) shstr = (shnum == 0) ? 16'($urandom) : 16'($urandom_range(0, shnum - 1));
      else if (r < 75) shstr = SHSTR_EXTENDED;
      else if (r < 85) shstr = shnum;
      else shstr = 16'($urandom);
      phoff = pick_offset(size, 64'(phnum) * 64'(phent), wide);
      shoff = pick_offset(size, 64'(shnum) * 64'(shent), wide);
      set_tables(wide, phoff, shoff, ehsize, phent, phnum, shent, shnum, shstr);

      r = $urandom_range(0, 99);
      if (r < 8) img[6'($urandom_range(0, 3))] ^= 8'(1 << $urandom_range(0, 7));
      else if (r < 12) img[6] = 8'($urandom);

      r = $urandom_range(0, 99);
      idle_pct = (r < 30) ? 0 : (r < 70) ? 10 : 40;
      send_file(size, ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 24));
   endtask

   initial begin
      int unsigned random_from;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 10;

      // Files too short to hold the identification bytes.
      base_header(ELFCLASS32, ELFDATA2LSB);
      send_file(64'd0, 0);
      send_file(64'd15, 0);
      // Identification faults: magic, class, encoding, version.
      base_header(ELFCLASS64, ELFDATA2LSB);
      img[2] = ~ELFMAG2;
      send_file(64'd16, 0);
      base_header(8'd0, ELFDATA2LSB);
      send_file(64'd64, 0);
      base_header(ELFCLASS64, 8'd3);
      send_file(64'd64, 0);
      base_header(ELFCLASS32, ELFDATA2LSB);
      img[6] = 8'd0;
      send_file(64'd52, 0);
      // One byte short of a full header, then the smallest valid files.
      base_header(ELFCLASS32, ELFDATA2LSB);
      send_file(64'd51, 0);
      base_header(ELFCLASS64, ELFDATA2LSB);
      send_file(64'd63, 0);
      base_header(ELFCLASS32, ELFDATA2LSB);
      send_file(64'd52, 0);
      base_header(ELFCLASS64, ELFDATA2LSB);
      send_file(64'd64, 5);
      base_header(ELFCLASS32, ELFDATA2MSB);
      send_file(64'd52, 0);
      base_header(ELFCLASS64, ELFDATA2MSB);
      send_file(64'd64, 0);
      // Header size field wrong.
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, '0, '0, EHDR32_BYTES, PHENT64, '0, SHENT64, '0, '0);
      send_file(64'd64, 0);
      // Extended string index with a table that ends exactly at the end of the file.
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, '0, 64'd64, EHDR64_BYTES, PHENT64, '0, SHENT64, 16'd2,
                 SHSTR_EXTENDED);
      send_file(64'd192, 0);
      // String index equal to the section count.
      base_header(ELFCLASS32, ELFDATA2LSB);
      set_tables(1'b0, '0, 64'd52, EHDR32_BYTES, PHENT32, '0, SHENT32, 16'd3, 16'd3);
      send_file(64'd172, 0);
      // Section offset at the file size with no sections.
      base_header(ELFCLASS32, ELFDATA2LSB);
      set_tables(1'b0, '0, 64'd500, EHDR32_BYTES, PHENT32, '0, SHENT32, '0, '0);
      send_file(64'd500, 0);
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, '0, 64'd64, EHDR64_BYTES, PHENT64, '0, SHENT32, 16'd1, '0);
      send_file(64'd128, 0);
      // Section table one byte past the end.
      base_header(ELFCLASS32, ELFDATA2LSB);
      set_tables(1'b0, '0, 64'd53, EHDR32_BYTES, PHENT32, '0, SHENT32, 16'd3, 16'd1);
      send_file(64'd172, 0);
      // Program header faults: offset at end, wrong entry size, one byte past the end.
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, 64'd1000, '0, EHDR64_BYTES, PHENT64, 16'd1, SHENT64, '0, '0);
      send_file(64'd1000, 0);
      base_header(ELFCLASS32, ELFDATA2LSB);
      set_tables(1'b0, 64'd52, '0, EHDR32_BYTES, 16'd56, 16'd1, SHENT32, '0, '0);
      send_file(64'd84, 0);
      base_header(ELFCLASS32, ELFDATA2LSB);
      set_tables(1'b0, 64'd52, '0, EHDR32_BYTES, PHENT32, 16'd2, SHENT32, '0, '0);
      send_file(64'd115, 0);
      // Largest file size with the largest tables ending at its last byte.
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, 64'hFFFF_FFFF_FFFF_FFFF - 64'd65535 * 64'd56,
                 64'hFFFF_FFFF_FFFF_FFFF - 64'd65535 * 64'd64, EHDR64_BYTES, PHENT64,
                 16'hFFFF, SHENT64, 16'hFFFF, 16'hFFFE);
      send_file(64'hFFFF_FFFF_FFFF_FFFF, 0);
      // An extent that would wrap past the top of the address range.
      base_header(ELFCLASS64, ELFDATA2LSB);
      set_tables(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFF5, EHDR64_BYTES, PHENT64, '0, SHENT64,
                 16'd1, '0);
      send_file(64'hFFFF_FFFF_FFFF_FFFF, 0);

      // Hold off the next request until every verdict so far is back.
      wait_for_verdicts();

      random_from = bytes_sent;
      while (bytes_sent - random_from < RANDOM_BYTES) begin
         idle_on = (bytes_sent - random_from < CALM_BYTES);
         random_file();
         if (idle_on && $urandom_range(0, 19) == 0) wait_for_verdicts();
      end

      start <= 1'b0;
      do @(posedge clock); while (board.expected_verdicts.size() != 0);
      repeat (8) @(posedge clock);

      $display("Judged %0d files from %0d request bytes: %0d invalid, %0d 32-bit,",
               board.tally[0] + board.tally[1] + board.tally[2] + board.tally[3],
               bytes_sent, board.tally[0], board.tally[1]);
      $display("%0d 64-bit, %0d too short; ident faults, size limits and table extents hit.",
               board.tally[2], board.tally[3]);
      if (board.errors == 0) begin
         $display("elf_header_validator_core test passed");
      end else begin
         $display("elf_header_validator_core test failed");
      end
      $finish;
   end

endmodule
